// ===== design/dtv_pkg.sv =====
// Shared types and constants for the date text validator.
package dtv_pkg;

    localparam logic [7:0] CH_NL  = 8'h0A;
    localparam logic [7:0] CH_DOT = 8'h2E;
    localparam logic [7:0] CH_0   = 8'h30;
    localparam logic [7:0] CH_9   = 8'h39;

    localparam logic [6:0] YEAR_LIMIT_RESET = 7'd50;
    localparam logic [5:0] DAY_MAX   = 6'd31;
    localparam logic [4:0] MONTH_MAX = 5'd12;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [3:0] ST_VALID       = 4'd0;
    localparam logic [3:0] ST_DAY_HI      = 4'd1;
    localparam logic [3:0] ST_DAY_LO      = 4'd2;
    localparam logic [3:0] ST_DAY_RANGE   = 4'd3;
    localparam logic [3:0] ST_DOT1        = 4'd4;
    localparam logic [3:0] ST_MONTH_HI    = 4'd5;
    localparam logic [3:0] ST_MONTH_LO    = 4'd6;
    localparam logic [3:0] ST_MONTH_RANGE = 4'd7;
    localparam logic [3:0] ST_DOT2        = 4'd8;
    localparam logic [3:0] ST_YEAR_HI     = 4'd9;
    localparam logic [3:0] ST_YEAR_LO     = 4'd10;
    localparam logic [3:0] ST_YEAR_RANGE  = 4'd11;
    localparam logic [3:0] ST_NO_NEWLINE  = 4'd12;
    localparam logic [3:0] ST_DAY_MONTH   = 4'd13;
    localparam logic [3:0] ST_NOT_LEAP    = 4'd14;

    typedef enum logic [3:0] {
        POS_DAY_HI,
        POS_DAY_LO,
        POS_DOT1,
        POS_MONTH_HI,
        POS_MONTH_LO,
        POS_DOT2,
        POS_YEAR_HI,
        POS_YEAR_LO,
        POS_NEWLINE,
        POS_SKIP
    } pos_t;

    typedef struct packed {
        logic       is_nl;
        logic       is_dot;
        logic       is_dig;
        logic [3:0] digit;
    } token_t;

    typedef struct packed {
        logic [5:0] year;
        logic [4:0] month;
        logic [5:0] day;
        logic [3:0] status;
    } result_t;

endpackage

// ===== design/dtv_front.sv =====
// Front end: accepts characters and classifies them into tokens for the queue.
module dtv_front
(
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // [7:0] char_code
    input  logic              q_full,
    output logic              q_push,
    output dtv_pkg::token_t   q_token
);

    logic [7:0] digit_wide;

    assign s_tready   = !q_full;
    assign q_push     = s_tvalid && !q_full;
    assign digit_wide = s_tdata - dtv_pkg::CH_0;

    always_comb
    begin
        q_token.is_nl  = (s_tdata == dtv_pkg::CH_NL);
        q_token.is_dot = (s_tdata == dtv_pkg::CH_DOT);
        q_token.is_dig = (s_tdata >= dtv_pkg::CH_0) && (s_tdata <= dtv_pkg::CH_9);
        q_token.digit  = digit_wide[3:0];
    end

endmodule

// ===== design/dtv_queue.sv =====
// Short token queue between the front end and the checker.
module dtv_queue
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  dtv_pkg::token_t   push_token,
    output logic              full,
    input  logic              pop,
    output logic              head_valid,
    output dtv_pkg::token_t   head_token
);

    dtv_pkg::token_t mem [dtv_pkg::QUEUE_DEPTH];

    logic [dtv_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [dtv_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [dtv_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [dtv_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [dtv_pkg::QUEUE_AW:0]   count_reg;
    logic [dtv_pkg::QUEUE_AW:0]   count_next;
    logic                         do_push;
    logic                         do_pop;

    assign full       = (count_reg == (dtv_pkg::QUEUE_AW + 1)'(dtv_pkg::QUEUE_DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_token = mem[rd_ptr_reg];
    assign do_push    = push && !full;
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = do_push ? wr_ptr_reg + 1'b1 : wr_ptr_reg;
        rd_ptr_next = do_pop  ? rd_ptr_reg + 1'b1 : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!do_push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_token;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

// ===== design/dtv_back.sv =====
// Back end: position checker, accumulators, year limit register and result register.
module dtv_back
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [6:0]        cfg_data,
    input  logic              q_valid,
    input  dtv_pkg::token_t   q_token,
    output logic              q_pop,
    output logic              m_tvalid,
    input  logic              m_tready,
    output logic [23:0]       m_tdata    // [3:0] status, [9:4] day, [14:10] month, [20:15] year
);

    dtv_pkg::pos_t   pos_reg;
    dtv_pkg::pos_t   pos_next;
    logic [5:0]      day_reg;
    logic [5:0]      day_next;
    logic [4:0]      month_reg;
    logic [4:0]      month_next;
    logic [5:0]      year_reg;
    logic [5:0]      year_next;
    logic [6:0]      year_limit_reg;
    logic            out_valid_reg;
    dtv_pkg::result_t out_reg;

    logic            emit;
    logic [3:0]      status;
    logic [5:0]      day_new;
    logic [4:0]      month_new;
    logic [5:0]      year_new;
    logic [5:0]      day_mac;
    logic [4:0]      month_mac;
    logic [5:0]      year_mac;
    logic            short_month;

    assign cfg_ready = 1'b1;
    assign q_pop     = q_valid && (!out_valid_reg || m_tready);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = {3'b000, out_reg};

    assign day_mac   = (day_reg << 3) + (day_reg << 1) + {2'b00, q_token.digit};
    assign month_mac = (month_reg << 3) + (month_reg << 1) + {1'b0, q_token.digit};
    assign year_mac  = (year_reg << 3) + (year_reg << 1) + {2'b00, q_token.digit};
    assign short_month = (month_reg == 5'd4) || (month_reg == 5'd6) ||
                         (month_reg == 5'd9) || (month_reg == 5'd11);

    always_comb
    begin
        emit      = 1'b0;
        status    = dtv_pkg::ST_VALID;
        day_new   = day_reg;
        month_new = month_reg;
        year_new  = year_reg;
        case (pos_reg)
            dtv_pkg::POS_DAY_HI:
            begin
                if (!(q_token.is_dig && q_token.digit <= 4'd3))
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_DAY_HI;
                end
                else
                begin
                    day_new = {2'b00, q_token.digit};
                end
            end
            dtv_pkg::POS_DAY_LO:
            begin
                if (!q_token.is_dig)
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_DAY_LO;
                end
                else
                begin
                    day_new = day_mac;
                    if (day_mac == '0 || day_mac > dtv_pkg::DAY_MAX)
                    begin
                        emit   = 1'b1;
                        status = dtv_pkg::ST_DAY_RANGE;
                    end
                end
            end
            dtv_pkg::POS_DOT1:
            begin
                if (!q_token.is_dot)
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_DOT1;
                end
            end
            dtv_pkg::POS_MONTH_HI:
            begin
                if (!(q_token.is_dig && q_token.digit <= 4'd1))
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_MONTH_HI;
                end
                else
                begin
                    month_new = {1'b0, q_token.digit};
                end
            end
            dtv_pkg::POS_MONTH_LO:
            begin
                if (!q_token.is_dig)
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_MONTH_LO;
                end
                else
                begin
                    month_new = month_mac;
                    if (month_mac == '0 || month_mac > dtv_pkg::MONTH_MAX)
                    begin
                        emit   = 1'b1;
                        status = dtv_pkg::ST_MONTH_RANGE;
                    end
                end
            end
            dtv_pkg::POS_DOT2:
            begin
                if (!q_token.is_dot)
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_DOT2;
                end
            end
            dtv_pkg::POS_YEAR_HI:
            begin
                if (!(q_token.is_dig && q_token.digit <= 4'd5))
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_YEAR_HI;
                end
                else
                begin
                    year_new = {2'b00, q_token.digit};
                end
            end
            dtv_pkg::POS_YEAR_LO:
            begin
                if (!q_token.is_dig)
                begin
                    emit   = 1'b1;
                    status = dtv_pkg::ST_YEAR_LO;
                end
                else
                begin
                    year_new = year_mac;
                    if (year_mac == '0 || {1'b0, year_mac} > year_limit_reg)
                    begin
                        emit   = 1'b1;
                        status = dtv_pkg::ST_YEAR_RANGE;
                    end
                end
            end
            dtv_pkg::POS_NEWLINE:
            begin
                emit = 1'b1;
                if (!q_token.is_nl)
                begin
                    status = dtv_pkg::ST_NO_NEWLINE;
                end
                else if (month_reg == 5'd2 && day_reg > 6'd29)
                begin
                    status = dtv_pkg::ST_DAY_MONTH;
                end
                else if (short_month && day_reg == dtv_pkg::DAY_MAX)
                begin
                    status = dtv_pkg::ST_DAY_MONTH;
                end
                else if (month_reg == 5'd2 && day_reg == 6'd29 && year_reg[1:0] != 2'b00)
                begin
                    status = dtv_pkg::ST_NOT_LEAP;
                end
                else
                begin
                    status = dtv_pkg::ST_VALID;
                end
            end
            default:
            begin
                emit = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        pos_next = pos_reg;
        if (q_pop)
        begin
            if (pos_reg == dtv_pkg::POS_SKIP)
            begin
                pos_next = q_token.is_nl ? dtv_pkg::POS_DAY_HI : dtv_pkg::POS_SKIP;
            end
            else if (emit)
            begin
                pos_next = (status != dtv_pkg::ST_VALID && !q_token.is_nl) ?
                           dtv_pkg::POS_SKIP : dtv_pkg::POS_DAY_HI;
            end
            else
            begin
                case (pos_reg)
                    dtv_pkg::POS_DAY_HI:   pos_next = dtv_pkg::POS_DAY_LO;
                    dtv_pkg::POS_DAY_LO:   pos_next = dtv_pkg::POS_DOT1;
                    dtv_pkg::POS_DOT1:     pos_next = dtv_pkg::POS_MONTH_HI;
                    dtv_pkg::POS_MONTH_HI: pos_next = dtv_pkg::POS_MONTH_LO;
                    dtv_pkg::POS_MONTH_LO: pos_next = dtv_pkg::POS_DOT2;
                    dtv_pkg::POS_DOT2:     pos_next = dtv_pkg::POS_YEAR_HI;
                    dtv_pkg::POS_YEAR_HI:  pos_next = dtv_pkg::POS_YEAR_LO;
                    dtv_pkg::POS_YEAR_LO:  pos_next = dtv_pkg::POS_NEWLINE;
                    default:               pos_next = dtv_pkg::POS_DAY_HI;
                endcase
            end
        end
    end

    always_comb
    begin
        day_next   = day_reg;
        month_next = month_reg;
        year_next  = year_reg;
        if (q_pop)
        begin
            if (emit || pos_reg == dtv_pkg::POS_SKIP)
            begin
                day_next   = '0;
                month_next = '0;
                year_next  = '0;
            end
            else
            begin
                day_next   = day_new;
                month_next = month_new;
                year_next  = year_new;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg        <= dtv_pkg::POS_DAY_HI;
            day_reg        <= '0;
            month_reg      <= '0;
            year_reg       <= '0;
            year_limit_reg <= dtv_pkg::YEAR_LIMIT_RESET;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pos_reg   <= pos_next;
            day_reg   <= day_next;
            month_reg <= month_next;
            year_reg  <= year_next;
            if (cfg_valid && cfg_ready)
            begin
                year_limit_reg <= cfg_data;
            end
            if (q_pop && emit)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_reg.status <= status;
            out_reg.day    <= day_new;
            out_reg.month  <= month_new;
            out_reg.year   <= year_new;
        end
    end

endmodule

// ===== design/date_text_validator_top.sv =====
// Top level of the date text validator: front end, token queue and checker.
//
// Usage:
//   The slave stream carries one ASCII character per request in s_tdata.
//   Lines of the form dd.mm.yy followed by a newline are checked; at the end
//   of a line, or at the first faulty character, one status request leaves
//   on the master stream with the day, month and year gathered so far.
//   After a fault that is not a newline, characters up to and including the
//   next newline are dropped without any result.
//   The cfg channel writes the largest accepted year; cfg_ready is always
//   high. Write it only while no character is in flight.
// Timing:
//   One character per cycle sustained while the master stream takes results;
//   a character is first stored in the token queue, and its result is then
//   registered onto m_tvalid when the position check in the back end pops it.
// Reset:
//   rst_n clears the queue, the position and accumulators, and loads a year
//   limit of 50.
// Stall:
//   While m_tready is low and a result waits, the checker holds and the
//   four-entry queue absorbs input; s_tready falls only when it is full.
module date_text_validator_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] char_code
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [23:0] m_tdata,   // [3:0] status, [9:4] day, [14:10] month, [20:15] year
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [6:0]  cfg_data   // [6:0] year_limit
);

    logic             q_full;
    logic             q_push;
    dtv_pkg::token_t  push_token;
    logic             q_pop;
    logic             head_valid;
    dtv_pkg::token_t  head_token;

    dtv_front u_front
    (
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .q_full   (q_full),
        .q_push   (q_push),
        .q_token  (push_token)
    );

    dtv_queue u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_token (push_token),
        .full       (q_full),
        .pop        (q_pop),
        .head_valid (head_valid),
        .head_token (head_token)
    );

    dtv_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .q_valid   (head_valid),
        .q_token   (head_token),
        .q_pop     (q_pop),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

// ===== tb/sv/tb_date_text_validator_top.sv =====
// Self-checking testbench for the date text validator: driver, predictor and monitor.
module tb_date_text_validator_top;

    timeunit 1ns;
    timeprecision 1ps;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata = '0;     // [7:0] char_code
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // [3:0] status, [9:4] day, [14:10] month, [20:15] year
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [6:0]  cfg_data = '0;    // [6:0] year_limit

    logic [7:0]       char_q [$];
    dtv_pkg::result_t status_q [$];

    dtv_pkg::pos_t line_pos = dtv_pkg::POS_DAY_HI;
    logic [5:0]    day_acc = '0;
    logic [4:0]    month_acc = '0;
    logic [5:0]    year_acc = '0;
    logic [6:0]    year_limit = dtv_pkg::YEAR_LIMIT_RESET;

    bit               idle_on = 1'b1;
    bit               char_taken = 1'b0;
    int               src_gap = 0;
    int               snk_gap = 0;
    int               chars_queued = 0;
    int               chars_accepted = 0;
    int               results_checked = 0;
    int               valid_dates = 0;
    int               fails = 0;
    dtv_pkg::result_t want;
    dtv_pkg::result_t got;
    dtv_pkg::result_t predicted;

    date_text_validator_top DUT
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        forever
        begin
            #5 clk = ~clk;
        end
    end

    initial
    begin
        #3_000_000;
        $display("Verification failed");
        $finish;
    end

    function automatic bit advance_date(input logic [7:0] c, output dtv_pkg::result_t res);
        logic [3:0] code;
        bit         ends;
        bit         digit;
        res = '0;
        code = dtv_pkg::ST_VALID;
        ends = 1'b0;
        digit = (c >= dtv_pkg::CH_0 && c <= dtv_pkg::CH_9);
        case (line_pos)
            dtv_pkg::POS_SKIP:
            begin
                if (c == dtv_pkg::CH_NL)
                    line_pos = dtv_pkg::POS_DAY_HI;
                return 1'b0;
            end
            dtv_pkg::POS_DAY_HI:
            begin
                if (c < dtv_pkg::CH_0 || c > dtv_pkg::CH_0 + 3)
                begin
                    code = dtv_pkg::ST_DAY_HI;
                    ends = 1'b1;
                end
                else
                    day_acc = {2'b00, c[3:0]};
            end
            dtv_pkg::POS_DAY_LO:
            begin
                if (!digit)
                begin
                    code = dtv_pkg::ST_DAY_LO;
                    ends = 1'b1;
                end
                else
                begin
                    day_acc = day_acc * 6'd10 + {2'b00, c[3:0]};
                    if (day_acc == 0 || day_acc > dtv_pkg::DAY_MAX)
                    begin
                        code = dtv_pkg::ST_DAY_RANGE;
                        ends = 1'b1;
                    end
                end
            end
            dtv_pkg::POS_DOT1:
            begin
                if (c != dtv_pkg::CH_DOT)
                begin
                    code = dtv_pkg::ST_DOT1;
                    ends = 1'b1;
                end
            end
            dtv_pkg::POS_MONTH_HI:
            begin
                if (c < dtv_pkg::CH_0 || c > dtv_pkg::CH_0 + 1)
                begin
                    code = dtv_pkg::ST_MONTH_HI;
                    ends = 1'b1;
                end
                else
                    month_acc = {1'b0, c[3:0]};
            end
            dtv_pkg::POS_MONTH_LO:
            begin
                if (!digit)
                begin
                    code = dtv_pkg::ST_MONTH_LO;
                    ends = 1'b1;
                end
                else
                begin
                    month_acc = month_acc * 5'd10 + {1'b0, c[3:0]};
                    if (month_acc == 0 || month_acc > dtv_pkg::MONTH_MAX)
                    begin
                        code = dtv_pkg::ST_MONTH_RANGE;
                        ends = 1'b1;
                    end
                end
            end
            dtv_pkg::POS_DOT2:
            begin
                if (c != dtv_pkg::CH_DOT)
                begin
                    code = dtv_pkg::ST_DOT2;
                    ends = 1'b1;
                end
            end
            dtv_pkg::POS_YEAR_HI:
            begin
                if (c < dtv_pkg::CH_0 || c > dtv_pkg::CH_0 + 5)
                begin
                    code = dtv_pkg::ST_YEAR_HI;
                    ends = 1'b1;
                end
                else
                    year_acc = {2'b00, c[3:0]};
            end
            dtv_pkg::POS_YEAR_LO:
            begin
                if (!digit)
                begin
                    code = dtv_pkg::ST_YEAR_LO;
                    ends = 1'b1;
                end
                else
                begin
                    year_acc = year_acc * 6'd10 + {2'b00, c[3:0]};
                    if (year_acc == 0 || year_acc > year_limit)
                    begin
                        code = dtv_pkg::ST_YEAR_RANGE;
                        ends = 1'b1;
                    end
                end
            end
            default:
            begin
                ends = 1'b1;
                if (c != dtv_pkg::CH_NL)
                    code = dtv_pkg::ST_NO_NEWLINE;
                else if (month_acc == 5'd2 && day_acc > 6'd29)
                    code = dtv_pkg::ST_DAY_MONTH;
                else if ((month_acc == 5'd4 || month_acc == 5'd6 || month_acc == 5'd9 ||
                          month_acc == 5'd11) && day_acc == 6'd31)
                    code = dtv_pkg::ST_DAY_MONTH;
                else if (month_acc == 5'd2 && day_acc == 6'd29 && year_acc[1:0] != 2'b00)
                    code = dtv_pkg::ST_NOT_LEAP;
                else
                    code = dtv_pkg::ST_VALID;
            end
        endcase
        if (!ends)
        begin
            line_pos = dtv_pkg::pos_t'(line_pos + 4'd1);
            return 1'b0;
        end
        res.status = code;
        res.day = day_acc;
        res.month = month_acc;
        res.year = year_acc;
        day_acc = '0;
        month_acc = '0;
        year_acc = '0;
        // drop the rest of a faulty line unless the fault was the newline itself
        line_pos = (code != dtv_pkg::ST_VALID && c != dtv_pkg::CH_NL) ?
                   dtv_pkg::POS_SKIP : dtv_pkg::POS_DAY_HI;
        return 1'b1;
    endfunction

    task automatic push_char(input logic [7:0] c);
        char_q.push_back(c);
        chars_queued++;
    endtask

    task automatic push_text(input string s);
        for (int i = 0; i < s.len(); i++)
            push_char(s[i]);
    endtask

    task automatic push_random_line();
        int         kind;
        int         dd;
        int         mm;
        int         yy;
        int         n;
        logic [7:0] txt [9];
        kind = $urandom_range(0, 99);
        if (kind < 12)
        begin
            n = $urandom_range(1, 12);
            repeat (n)
                push_char(8'($urandom_range(0, 255)));
            if ($urandom_range(0, 1))
                push_char(dtv_pkg::CH_NL);
            return;
        end
        if ($urandom_range(0, 3) == 0)
        begin
            dd = $urandom_range(0, 39);
            mm = $urandom_range(0, 19);
            yy = $urandom_range(0, 59);
        end
        else
        begin
            mm = $urandom_range(1, 12);
            dd = (mm == 2 && $urandom_range(0, 1)) ?
                 $urandom_range(27, 31) : $urandom_range(1, 31);
            yy = $urandom_range(1, 59);
        end
        txt[0] = 8'(dtv_pkg::CH_0 + dd / 10);
        txt[1] = 8'(dtv_pkg::CH_0 + dd % 10);
        txt[2] = dtv_pkg::CH_DOT;
        txt[3] = 8'(dtv_pkg::CH_0 + mm / 10);
        txt[4] = 8'(dtv_pkg::CH_0 + mm % 10);
        txt[5] = dtv_pkg::CH_DOT;
        txt[6] = 8'(dtv_pkg::CH_0 + yy / 10);
        txt[7] = 8'(dtv_pkg::CH_0 + yy % 10);
        txt[8] = dtv_pkg::CH_NL;
        n = 9;
        if (kind < 32)
            txt[$urandom_range(0, 8)] = 8'($urandom_range(0, 255));
        else if (kind < 40)
        begin
            n = $urandom_range(1, 8);
            txt[n - 1] = dtv_pkg::CH_NL;
        end
        for (int i = 0; i < n; i++)
            push_char(txt[i]);
    endtask

    task automatic wait_idle();
        while (char_q.size() != 0 || s_tvalid || status_q.size() != 0)
            @(posedge clk);
        // let dropped characters drain out of the input queue
        repeat (16) @(posedge clk);
    endtask

    task automatic write_year_limit(input logic [6:0] v);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
        year_limit = v;
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && s_tvalid && s_tready)
        begin
            char_taken = 1'b1;
            chars_accepted++;
            if (advance_date(s_tdata, predicted))
                status_q.push_back(predicted);
        end
    end

    always @(negedge clk)
    begin
        if (rst_n && (!s_tvalid || char_taken))
        begin
            if (src_gap > 0)
            begin
                src_gap--;
                s_tvalid <= 1'b0;
            end
            else if (idle_on && $urandom_range(0, 9) == 0)
            begin
                src_gap = $urandom_range(1, 17) - 1;
                s_tvalid <= 1'b0;
            end
            else if (char_q.size() != 0)
            begin
                s_tvalid <= 1'b1;
                s_tdata <= char_q.pop_front();
            end
            else
                s_tvalid <= 1'b0;
        end
        char_taken = 1'b0;
    end

    always @(negedge clk)
    begin
        if (snk_gap > 0)
        begin
            snk_gap--;
            m_tready <= 1'b0;
        end
        else if (idle_on && $urandom_range(0, 7) == 0)
        begin
            snk_gap = $urandom_range(1, 17) - 1;
            m_tready <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            got = m_tdata[20:0];
            results_checked++;
            if (status_q.size() == 0)
            begin
                $error("status request with none expected: %h", m_tdata);
                fails++;
            end
            else
            begin
                want = status_q.pop_front();
                if (want.status == dtv_pkg::ST_VALID)
                    valid_dates++;
                if (got.status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, got.status);
                    fails++;
                end
                if (got.day !== want.day)
                begin
                    $error("day: expected %0d, got %0d", want.day, got.day);
                    fails++;
                end
                if (got.month !== want.month)
                begin
                    $error("month: expected %0d, got %0d", want.month, got.month);
                    fails++;
                end
                if (got.year !== want.year)
                begin
                    $error("year: expected %0d, got %0d", want.year, got.year);
                    fails++;
                end
            end
        end
    end

    initial
    begin
        string      lines [$];
        logic [6:0] lim;
        int         start;
        lines = '{"31.12.50\n", "01.01.01\n", "29.02.48\n", "\n", "4zz\n", "1\n",
                  "00\n", "32\n", "12-\n", "12.2\n", "12.1a\n", "12.13\n", "12.00\n",
                  "12.12/\n", "12.12.6\n", "12.12.1:\n", "12.12.51\n", "12.12.00\n",
                  "12.12.12x\n", "30.02.20\n", "31.04.20\n", "29.02.21\n"};
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        foreach (lines[i])
            push_text(lines[i]);
        push_char(8'hFF);
        push_char(8'h80);
        push_char(8'h00);
        push_char(dtv_pkg::CH_NL);

        for (int p = 0; p < 7; p++)
        begin
            wait_idle();
            case (p)
                0: lim = 7'd0;
                1: lim = 7'd127;
                2: lim = 7'd1;
                3: lim = 7'd99;
                6: lim = dtv_pkg::YEAR_LIMIT_RESET;
                default: lim = 7'($urandom_range(2, 98));
            endcase
            idle_on = (p != 6);
            write_year_limit(lim);
            start = chars_queued;
            while (chars_queued - start < 55)
                push_random_line();
        end
        wait_idle();

        $display("Sent %0d characters under seven year limits (0, 1, 99, 127 among them);",
                 chars_accepted);
        $display("checked %0d status results, %0d of them valid dates.",
                 results_checked, valid_dates);
        if (fails == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== sim.f =====
design/dtv_pkg.sv
design/dtv_front.sv
design/dtv_queue.sv
design/dtv_back.sv
design/date_text_validator_top.sv
tb/sv/tb_date_text_validator_top.sv
